// ===== src/jbt_pkg.sv =====
package jbt_pkg;

  // Longest string or decimal value the token store holds
  localparam int MAX_TOKEN_LEN = 32;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int ADDR_W        = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    K_LCURLY       = 4'd0,
    K_RCURLY       = 4'd1,
    K_LBRAC        = 4'd2,
    K_RBRAC        = 4'd3,
    K_COMMA        = 4'd4,
    K_COLON        = 4'd5,
    K_TRUE         = 4'd6,
    K_FALSE        = 4'd7,
    K_NULL         = 4'd8,
    K_STRING       = 4'd9,
    K_DECIMAL      = 4'd10,
    K_ERR_STRING   = 4'd11,
    K_ERR_WORD     = 4'd12,
    K_ERR_OVERFLOW = 4'd13
  } kind_t;

  // One queued command: a single result, or a dump of the token store
  typedef struct packed {
    kind_t             kind;
    logic              dump;
    logic [LEN_W-1:0]  len;
    logic              last;
  } cmd_t;

  // Token store write port, driven by the front
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

// ===== src/jbt_front.sv =====
module jbt_front import jbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic      s_tuser,    // [0] func
  output logic      push,
  output cmd_t      push_cmd,
  input  logic      q_full,
  input  logic      dump_done,
  output store_wr_t wr
);

  typedef enum logic [1:0] {M_IDLE, M_STR, M_WORD, M_SKIP} mode_t;

  // Running status of the token being collected
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [1:0]       dash;
    logic [1:0]       dot;
    logic             foreign;
    logic             kw_t;
    logic             kw_f;
    logic             kw_n;
    logic             first_dot;
    logic             last_dot;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{len: '0, dash: 2'd0, dot: 2'd0, foreign: 1'b0,
                                 kw_t: 1'b1, kw_f: 1'b1, kw_n: 1'b1,
                                 first_dot: 1'b0, last_dot: 1'b0};

  function automatic logic [7:0] true_char(logic [2:0] p);
    case (p)
      3'd0:    return "t";
      3'd1:    return "r";
      3'd2:    return "u";
      default: return "e";
    endcase
  endfunction

  function automatic logic [7:0] false_char(logic [2:0] p);
    case (p)
      3'd0:    return "f";
      3'd1:    return "a";
      3'd2:    return "l";
      3'd3:    return "s";
      default: return "e";
    endcase
  endfunction

  function automatic logic [7:0] null_char(logic [2:0] p);
    case (p)
      3'd0:    return "n";
      3'd1:    return "u";
      default: return "l";
    endcase
  endfunction

  // Status after one more byte goes into the store
  function automatic tok_t tok_append(tok_t t, logic [7:0] c, logic word);
    tok_t       r;
    logic [5:0] p;
    r = t;
    p = 6'(t.len);
    r.len       = LEN_W'(t.len + 1'b1);
    r.kw_t      = t.kw_t && (p < 6'd4) && (c == true_char(p[2:0]));
    r.kw_f      = t.kw_f && (p < 6'd5) && (c == false_char(p[2:0]));
    r.kw_n      = t.kw_n && (p < 6'd4) && (c == null_char(p[2:0]));
    r.first_dot = (p == 6'd0) ? (c == ".") : t.first_dot;
    r.last_dot  = (c == ".");
    if (word) begin
      if (c == "-") begin
        if (t.dash != 2'd2) r.dash = t.dash + 2'd1;
      end else if (c == ".") begin
        if (t.dot != 2'd2) r.dot = t.dot + 2'd1;
      end else if (c < "0" || c > "9") begin
        r.foreign = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic cmd_t mk_single(kind_t k);
    cmd_t r;
    r.kind = k;
    r.dump = 1'b0;
    r.len  = '0;
    r.last = 1'b0;
    return r;
  endfunction

  mode_t      mode;
  mode_t      mode_next;
  tok_t       tok;
  tok_t       tok_next;
  tok_t       appended;
  tok_t       fresh;
  logic       hold_v;
  cmd_t       hold_cmd;
  logic       lock;

  logic       accept;
  logic [7:0] c;
  logic       is_space;
  logic       is_quote;
  logic       is_punct;
  kind_t      pk;
  logic [5:0] tlen6;
  logic       is_true;
  logic       is_false;
  logic       is_null;
  logic       fin_ok;
  logic       fin_bad;
  cmd_t       fin_cmd;
  logic       ovf;
  logic       do_idle;
  logic       wr_req;
  logic [ADDR_W-1:0] wr_addr;
  cmd_t       c0;
  cmd_t       c1;
  logic       c0v;
  logic       c1v;

  assign c        = s_tdata;
  assign s_tready = !hold_v && !lock && !q_full;
  assign accept   = s_tvalid && s_tready;

  // Classify the byte
  always_comb begin
    is_punct = 1'b1;
    pk       = K_LCURLY;
    case (c)
      "{":     pk = K_LCURLY;
      "}":     pk = K_RCURLY;
      "[":     pk = K_LBRAC;
      "]":     pk = K_RBRAC;
      ",":     pk = K_COMMA;
      ":":     pk = K_COLON;
      default: is_punct = 1'b0;
    endcase
  end

  assign is_space = (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A) || (c == 8'h20);
  assign is_quote = (c == 8'h22);

  // Classify the word collected so far
  assign tlen6    = 6'(tok.len);
  assign is_true  = (tlen6 == 6'd4) && tok.kw_t;
  assign is_false = (tlen6 == 6'd5) && tok.kw_f;
  assign is_null  = (tlen6 == 6'd4) && tok.kw_n;
  assign fin_ok   = (tlen6 != 6'd0) && !tok.foreign && (tok.dash != 2'd2) &&
                    (tok.dot != 2'd2) && !tok.first_dot && !tok.last_dot;
  assign fin_bad  = !is_true && !is_false && !is_null && !fin_ok;
  assign ovf      = tlen6 >= 6'(MAX_TOKEN_LEN);
  assign appended = tok_append(tok, c, mode == M_WORD);
  assign fresh    = tok_append(TOK_CLEAR, c, 1'b1);

  always_comb begin
    fin_cmd = mk_single(K_ERR_WORD);
    if (is_true) begin
      fin_cmd.kind = K_TRUE;
    end else if (is_false) begin
      fin_cmd.kind = K_FALSE;
    end else if (is_null) begin
      fin_cmd.kind = K_NULL;
    end else if (fin_ok) begin
      fin_cmd.kind = K_DECIMAL;
      fin_cmd.dump = 1'b1;
      fin_cmd.len  = tok.len;
    end
  end

  // Next lexer state and the commands this item raises
  always_comb begin
    mode_next = mode;
    tok_next  = tok;
    c0        = mk_single(K_LCURLY);
    c1        = mk_single(K_LCURLY);
    c0v       = 1'b0;
    c1v       = 1'b0;
    do_idle   = 1'b0;
    wr_req    = 1'b0;
    wr_addr   = tok.len[ADDR_W-1:0];
    if (s_tuser) begin
      if (mode == M_STR) begin
        c0v = 1'b1;
        c0  = mk_single(K_ERR_STRING);
      end else if (mode == M_WORD) begin
        c0v = 1'b1;
        c0  = fin_cmd;
      end
      mode_next = M_IDLE;
      tok_next  = TOK_CLEAR;
    end else begin
      case (mode)
        M_STR: begin
          if (is_quote) begin
            c0v       = 1'b1;
            c0        = mk_single(K_STRING);
            c0.dump   = (tok.len != '0);
            c0.len    = tok.len;
            mode_next = M_IDLE;
            tok_next  = TOK_CLEAR;
          end else if (ovf) begin
            c0v       = 1'b1;
            c0        = mk_single(K_ERR_OVERFLOW);
            mode_next = M_SKIP;
            tok_next  = TOK_CLEAR;
          end else begin
            wr_req   = 1'b1;
            tok_next = appended;
          end
        end
        M_WORD: begin
          if (is_punct || is_quote || is_space) begin
            c0v      = 1'b1;
            c0       = fin_cmd;
            tok_next = TOK_CLEAR;
            if (fin_bad) begin
              mode_next = M_SKIP;
            end else begin
              mode_next = M_IDLE;
              do_idle   = 1'b1;
            end
          end else if (ovf) begin
            c0v       = 1'b1;
            c0        = mk_single(K_ERR_OVERFLOW);
            mode_next = M_SKIP;
            tok_next  = TOK_CLEAR;
          end else begin
            wr_req   = 1'b1;
            tok_next = appended;
          end
        end
        M_IDLE: begin
          do_idle = 1'b1;
        end
        default: begin
        end
      endcase
      // Start of a new token, or a punctuation result
      if (do_idle) begin
        if (is_punct) begin
          c1v = 1'b1;
          c1  = mk_single(pk);
        end else if (is_quote) begin
          mode_next = M_STR;
          tok_next  = TOK_CLEAR;
        end else if (!is_space) begin
          mode_next = M_WORD;
          tok_next  = fresh;
          wr_req    = 1'b1;
          wr_addr   = '0;
        end
      end
    end
    // Mark the final result of the item
    if (c1v) begin
      c1.last = 1'b1;
    end else begin
      c0.last = 1'b1;
    end
  end

  assign wr.en   = accept && wr_req;
  assign wr.addr = wr_addr;
  assign wr.data = c;

  assign push     = hold_v ? !q_full : (accept && (c0v || c1v));
  assign push_cmd = hold_v ? hold_cmd : (c0v ? c0 : c1);

  // Hold lexer state; lock out new bytes while the store is being dumped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      tok    <= TOK_CLEAR;
      hold_v <= 1'b0;
      lock   <= 1'b0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        tok  <= tok_next;
        if (c0v && c1v) hold_v <= 1'b1;
      end
      if (hold_v && !q_full) hold_v <= 1'b0;
      if (push && push_cmd.dump) begin
        lock <= 1'b1;
      end else if (dump_done) begin
        lock <= 1'b0;
      end
    end
  end

  // Park the second command of an item
  always_ff @(posedge clk) begin
    if (accept && c0v && c1v) hold_cmd <= c1;
  end

endmodule

// ===== src/jbt_cmd_fifo.sv =====
module jbt_cmd_fifo import jbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_cmd;
  end

endmodule

// ===== src/jbt_back.sv =====
module jbt_back import jbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  store_wr_t   wr,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        dump_done,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] value_byte, [8] token_end
  output logic [4:0]  m_tuser,   // [3:0] token_kind, [4] value_valid
  output logic        m_tlast    // last
);

  typedef enum logic {B_IDLE, B_DUMP} bstate_t;

  logic [7:0]        store [MAX_TOKEN_LEN];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  bstate_t           state;
  cmd_t              cur;
  logic [ADDR_W-1:0] idx;
  logic              slot_free;
  logic              at_end;

  kind_t             out_kind;
  logic [7:0]        out_byte;
  logic              out_vv;
  logic              out_end;

  assign slot_free = !m_tvalid || m_tready;
  assign at_end    = (LEN_W'(LEN_W'(idx) + 1'b1) == cur.len);
  assign pop       = (state == B_IDLE) && q_valid && (q_cmd.dump || slot_free);
  assign rd_en     = ((state == B_IDLE) && q_valid && q_cmd.dump) ||
                     ((state == B_DUMP) && slot_free && !at_end);
  assign rd_addr   = (state == B_IDLE) ? '0 : ADDR_W'(idx + 1'b1);
  assign dump_done = (state == B_DUMP) && slot_free && at_end;

  // Token store: written by the front, read here one byte at a time
  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr] <= wr.data;
    if (rd_en) rd_data <= store[rd_addr];
  end

  // Run commands into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (pop && !q_cmd.dump) begin
            m_tvalid <= 1'b1;
            out_kind <= q_cmd.kind;
            out_byte <= 8'd0;
            out_vv   <= 1'b0;
            out_end  <= 1'b1;
            m_tlast  <= q_cmd.last;
          end else begin
            // Drop the result once it has been taken
            if (m_tready) m_tvalid <= 1'b0;
            if (pop) begin
              cur   <= q_cmd;
              idx   <= '0;
              state <= B_DUMP;
            end
          end
        end
        B_DUMP: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            out_kind <= cur.kind;
            out_byte <= rd_data;
            out_vv   <= 1'b1;
            out_end  <= at_end;
            m_tlast  <= cur.last && at_end;
            if (at_end) begin
              state <= B_IDLE;
            end else begin
              idx <= ADDR_W'(idx + 1'b1);
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, out_end, out_byte};
  assign m_tuser = {out_vv, out_kind};

endmodule

// ===== src/json_byte_tokenizer.sv =====
// Streaming JSON tokenizer. Text bytes (s_tuser 0) or end-of-line markers
// (s_tuser 1) come in one per transfer; tokens go out as one transfer per
// result, with m_tlast on the final result of each input transfer. A byte
// that only extends a string or a word goes straight into the token store.
// Punctuation, keywords and errors leave as a single result, queued and
// then registered into the output. When a string or decimal closes, its
// bytes are read back from the token store one per cycle while the output
// is not stalled, through a registered read port, and no new byte is taken
// until that dump has finished. An input that closes a word and also
// carries punctuation parks its second command and queues it after the first.
// The store holds up to MAX_TOKEN_LEN bytes and needs no clearing after reset.
module json_byte_tokenizer import jbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] value_byte, [8] token_end, [15:9] zero
  output logic [4:0]  m_tuser,   // [3:0] token_kind, [4] value_valid
  output logic        m_tlast    // last
);

  logic      push;
  cmd_t      push_cmd;
  logic      q_full;
  logic      pop;
  logic      q_valid;
  cmd_t      q_cmd;
  logic      dump_done;
  store_wr_t wr;

  jbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .dump_done (dump_done),
    .wr        (wr)
  );

  jbt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  jbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .dump_done (dump_done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== src/jbt_checker.sv =====
module jbt_checker import jbt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("result changed while stalled");

  // Only strings and decimals carry value bytes
  a_value_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> (m_tuser[3:0] == K_STRING) ||
                               (m_tuser[3:0] == K_DECIMAL))
    else $error("value byte on a token without a value");

  // A result without a value closes its token
  a_novalue_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[4] |-> m_tdata[8])
    else $error("valueless result does not end its token");

  // The last result of an input also ends a token
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8])
    else $error("last result inside a token");

  // Nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind json_byte_tokenizer jbt_checker u_chk (.*);
